FILE: hdl/tccs_pkg.sv
// Shared types and constants for the text console cursor and scroll engine.
package tccs_pkg;

  typedef logic [1:0] action_t;

  localparam action_t ACT_PUT   = 2'd0;
  localparam action_t ACT_CLEAR = 2'd1;
  localparam action_t ACT_READ  = 2'd2;

  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_LF      = 8'd10;
  localparam logic [7:0] CH_BLANK   = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'h07;

  typedef struct packed {
    action_t    action;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_linear;
    logic        scrolled;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
  } out_item_t;

endpackage

FILE: hdl/text_console_cursor_scroll.sv
// Text console engine: cell store, cursor, scroll and clear sequencer.
// Each accepted item is decoded in S_EXEC. CR, newline without scroll, an unused action and an
// out-of-range read go to S_FIN; a written character passes S_PUT, an in-range read S_RDW.
// A scroll runs the S_SCP/S_SFL copy and S_SBL blank sweeps first; clear sweeps S_CLR. One item
// is in flight; S_FIN waits while the last result is untaken, then registers it and reopens input.
// Reset: a clearing pass blanks the store with attribute 0x07; no item is accepted until it ends.
module text_console_cursor_scroll #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tccs_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tccs_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);
  import tccs_pkg::*;

  localparam int NCELLS = COLS * ROWS;
  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(NCELLS);

  localparam logic [ADDR_W-1:0] LAST_A    = ADDR_W'(NCELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_N    = ADDR_W'(COLS * (ROWS - 1));
  localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(COLS * (ROWS - 1) - 1);
  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLS);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);

  typedef enum logic [9:0] {
    S_INIT = 10'b0000000001,
    S_IDLE = 10'b0000000010,
    S_EXEC = 10'b0000000100,
    S_PUT  = 10'b0000001000,
    S_SCP  = 10'b0000010000,
    S_SFL  = 10'b0000100000,
    S_SBL  = 10'b0001000000,
    S_CLR  = 10'b0010000000,
    S_RDW  = 10'b0100000000,
    S_FIN  = 10'b1000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [7:0]        attr_r, attr_nxt;
  logic              cpv_r, cpv_nxt;
  logic              put_after_r, put_after_nxt;
  logic              scrolled_r, scrolled_nxt;
  logic              out_valid_r, out_valid_nxt;

  in_item_t          item_r, item_nxt;
  logic [ADDR_W-1:0] wa_r, wa_nxt;
  logic [15:0]       cell_r, cell_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic [15:0]       mem [NCELLS];
  logic [15:0]       mem_rd_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [15:0]       mem_wd;

  logic [ADDR_W-1:0] cur_addr, rd_addr;
  logic              rd_in_range;

  assign cur_addr = ADDR_W'(ADDR_W'(row_r) * COLS_A + ADDR_W'(col_r));
  assign rd_addr  = ADDR_W'(ADDR_W'(item_r.read_row) * COLS_A + ADDR_W'(item_r.read_col));
  assign rd_in_range = (32'(item_r.read_row) < ROWS) && (32'(item_r.read_col) < COLS);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    attr_nxt      = cfg_we ? cfg_wdata : attr_r;
    cpv_nxt       = cpv_r;
    put_after_nxt = put_after_r;
    scrolled_nxt  = scrolled_r;
    out_valid_nxt = out_valid_r && !out_ready;
    item_nxt      = item_r;
    wa_nxt        = wa_r;
    cell_nxt      = cell_r;
    out_item_nxt  = out_item_r;
    mem_we        = 1'b0;
    mem_wa        = cnt_r;
    mem_wd        = {attr_r, CH_BLANK};
    mem_ra        = cnt_r;
    case (state_r)
      S_INIT: begin
        mem_we = 1'b1;
        mem_wd = {ATTR_RESET, CH_BLANK};
        if (cnt_r == LAST_A) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt     = in_item;
          scrolled_nxt = 1'b0;
          cell_nxt     = '0;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FIN;
        case (item_r.action)
          ACT_PUT: begin
            if (item_r.char_code == CH_CR) begin
              col_nxt = '0;
            end else if (item_r.char_code == CH_LF || col_r == COL_LAST) begin
              col_nxt       = '0;
              put_after_nxt = (item_r.char_code != CH_LF);
              if (row_r == ROW_LAST) begin
                cnt_nxt      = '0;
                cpv_nxt      = 1'b0;
                scrolled_nxt = 1'b1;
                state_nxt    = S_SCP;
              end else begin
                row_nxt = row_r + 1'b1;
                if (item_r.char_code != CH_LF) state_nxt = S_PUT;
              end
            end else begin
              state_nxt = S_PUT;
            end
          end
          ACT_CLEAR: begin
            col_nxt   = '0;
            row_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_CLR;
          end
          ACT_READ: begin
            mem_ra = rd_addr;
            if (rd_in_range) state_nxt = S_RDW;
          end
          default: ;
        endcase
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_wa    = cur_addr;
        mem_wd    = {attr_r, item_r.char_code};
        col_nxt   = col_r + 1'b1;
        state_nxt = S_FIN;
      end
      S_SCP: begin
        mem_ra  = cnt_r + COLS_A;
        mem_we  = cpv_r;
        mem_wa  = wa_r;
        mem_wd  = mem_rd_r;
        wa_nxt  = cnt_r;
        cpv_nxt = 1'b1;
        if (cnt_r == COPY_LAST) begin
          state_nxt = S_SFL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SFL: begin
        mem_we    = 1'b1;
        mem_wa    = wa_r;
        mem_wd    = mem_rd_r;
        cnt_nxt   = COPY_N;
        state_nxt = S_SBL;
      end
      S_SBL: begin
        mem_we = 1'b1;
        if (cnt_r == LAST_A) begin
          cnt_nxt   = '0;
          state_nxt = put_after_r ? S_PUT : S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_CLR: begin
        mem_we = 1'b1;
        if (cnt_r == LAST_A) begin
          cnt_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_RDW: begin
        cell_nxt  = mem_rd_r;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_item_nxt.cursor_col    = 7'(col_r);
          out_item_nxt.cursor_row    = 5'(row_r);
          out_item_nxt.cursor_linear = 11'(cur_addr);
          out_item_nxt.scrolled      = scrolled_r;
          out_item_nxt.cell_char     = cell_r[7:0];
          out_item_nxt.cell_attr     = cell_r[15:8];
          out_valid_nxt              = 1'b1;
          state_nxt                  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      attr_r      <= ATTR_RESET;
      cpv_r       <= 1'b0;
      put_after_r <= 1'b0;
      scrolled_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      attr_r      <= attr_nxt;
      cpv_r       <= cpv_nxt;
      put_after_r <= put_after_nxt;
      scrolled_r  <= scrolled_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    wa_r       <= wa_nxt;
    cell_r     <= cell_nxt;
    out_item_r <= out_item_nxt;
  end

  // cell store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_r <= mem[mem_ra];
  end

endmodule
